[design/window_coefficient_generator_core_assert.svh]
// Assertion macros shared by the window coefficient generator RTL.
`ifndef WINDOW_COEFFICIENT_GENERATOR_CORE_ASSERT_SVH
`define WINDOW_COEFFICIENT_GENERATOR_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define WCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wcg: implication check failed");

// Invariant checked at every clock edge outside reset.
`define WCG_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("wcg: invariant check failed");

`endif

[design/wcg_pkg.sv]
// Types, constants and coefficient tables of the window coefficient generator.
`default_nettype none
package wcg_pkg;

  localparam int IDX_W   = 16;
  localparam int LEN_W   = 17;
  localparam int TYPE_W  = 3;
  localparam int COEF_W  = 17;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 17;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TYPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 8'd1;

  // window type codes
  localparam logic [TYPE_W-1:0] WIN_RECT    = 3'd0;
  localparam logic [TYPE_W-1:0] WIN_HANN    = 3'd1;
  localparam logic [TYPE_W-1:0] WIN_HAMMING = 3'd2;
  localparam logic [TYPE_W-1:0] WIN_BLACKMAN = 3'd3;
  localparam logic [TYPE_W-1:0] WIN_BH4     = 3'd4;

  localparam logic [TYPE_W-1:0] TYPE_RESET = WIN_HANN;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 17'd1024;
  localparam logic [LEN_W-1:0]  LEN_MAX    = 17'd65536;

  // one cell per dividend bit: 16 index bits plus 32 fraction bits
  localparam int DIV_CELLS = 48;
  // Horner steps of the cosine series, the last one divides by two
  localparam int HCELLS = 6;
  // fold, angle, square, two stages per Horner step, sign
  localparam int LANE_STAGES = 3 + 2 * HCELLS + 1;

  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int RECIP_SHIFT = 37;

  localparam logic [COEF_W-1:0] ONE_OUT = 17'h10000;
  localparam logic [60:0] TOP_W = 61'h1000_0000_0000_0000;
  localparam logic [61:0] ROUND_HALF = 62'h800_0000_0000;
  localparam int OUT_SHIFT = 44;

  typedef logic [30:0] wcg_q30_t;

  // sideband that travels with each beat
  typedef struct packed {
    logic in_range;
    logic special;
  } wcg_side_t;

  // divider cell state
  typedef struct packed {
    logic [15:0] d;
    logic [15:0] rem;
    logic [47:0] num;
    logic [31:0] quo;
    wcg_side_t   side;
  } wcg_div_t;

  // Horner cell state
  typedef struct packed {
    logic [31:0]        y;
    logic signed [31:0] t;
    logic               neg;
  } wcg_hcell_t;

  // power-of-two part of each Horner divisor (132, 90, 56, 30, 12, 2)
  function automatic int horner_shift(input int step);
    int s;
    case (step)
      0: s = 2;
      1: s = 1;
      2: s = 3;
      3: s = 1;
      4: s = 2;
      default: s = 1;
    endcase
    return s;
  endfunction

  // ceil(2^37 / odd part), exact for operands below 2^37 / odd part
  function automatic logic [37:0] horner_recip(input int step);
    logic [37:0] m;
    case (step)
      0: m = 38'd4164816772;
      1: m = 38'd3054198967;
      2: m = 38'd19634136211;
      3: m = 38'd9162596899;
      4: m = 38'd45812984491;
      default: m = 38'd137438953472;
    endcase
    return m;
  endfunction

  // cosine-sum coefficient k of a window type, Q1.30
  function automatic wcg_q30_t win_coef(input logic [TYPE_W-1:0] wtype, input int k);
    logic [30:0] a0, a1, a2, a3;
    unique case (wtype)
      WIN_HANN: begin
        a0 = 31'd536870912; a1 = 31'd536870912; a2 = '0; a3 = '0;
      end
      WIN_HAMMING: begin
        a0 = 31'd579820585; a1 = 31'd493921239; a2 = '0; a3 = '0;
      end
      WIN_BLACKMAN: begin
        a0 = 31'd450971566; a1 = 31'd536870912; a2 = 31'd85899346; a3 = '0;
      end
      WIN_BH4: begin
        a0 = 31'd385204879; a1 = 31'd524297395; a2 = 31'd151698245; a3 = 31'd12541305;
      end
      default: begin
        a0 = 31'd1073741824; a1 = '0; a2 = '0; a3 = '0;
      end
    endcase
    case (k)
      0: return a0;
      1: return a1;
      2: return a2;
      default: return a3;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/wcg_if.sv]
// Channel interfaces of the window coefficient generator.
`default_nettype none
interface wcg_in_if;
  logic                       valid;
  logic                       ready;
  logic [wcg_pkg::IDX_W-1:0]  sample_index;
  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface wcg_out_if;
  logic                       valid;
  logic                       ready;
  logic [wcg_pkg::COEF_W-1:0] coefficient;
  logic                       index_in_range;
  modport source (output valid, output coefficient, output index_in_range, input ready);
  modport sink (input valid, input coefficient, input index_in_range, output ready);
endinterface

interface wcg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wcg_pkg::CFG_IDX_W-1:0]  index;
  logic [wcg_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/wcg_div_cell.sv]
// One restoring-division cell: takes one dividend bit, emits one quotient bit.
`default_nettype none
module wcg_div_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire wcg_pkg::wcg_div_t div_i,
  output logic                   valid_o,
  output wcg_pkg::wcg_div_t      div_o
);
  logic [16:0]       shifted;
  logic              take;
  wcg_pkg::wcg_div_t div_nxt;
  logic              valid_r;
  wcg_pkg::wcg_div_t div_r;

  // shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    shifted = {div_i.rem, div_i.num[47]};
    take    = shifted >= {1'b0, div_i.d};
    div_nxt = div_i;
    div_nxt.rem = take ? 16'(shifted - {1'b0, div_i.d}) : shifted[15:0];
    div_nxt.num = {div_i.num[46:0], 1'b0};
    div_nxt.quo = {div_i.quo[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign valid_o = valid_r;
  assign div_o   = div_r;
endmodule
`default_nettype wire

[design/wcg_horner_cell.sv]
// One Horner step of the cosine series: t' = 1 - floor(floor(y*t)/div).
`default_nettype none
module wcg_horner_cell #(
  parameter int STEP = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                valid_i,
  input  wire wcg_pkg::wcg_hcell_t cell_i,
  output logic                     valid_o,
  output wcg_pkg::wcg_hcell_t      cell_o
);
  localparam int          SHIFT = wcg_pkg::horner_shift(STEP);
  localparam logic [37:0] RECIP = wcg_pkg::horner_recip(STEP);

  logic [62:0]         prod_a;
  logic [69:0]         prod_b;
  logic [31:0]         quo;
  logic                a_valid_r;
  logic [31:0]         a_v_r;
  logic [31:0]         a_y_r;
  logic                a_neg_r;
  logic                valid_r;
  wcg_pkg::wcg_hcell_t cell_r;

  // product y*t back to Q2.30
  assign prod_a = 63'(cell_i.y) * 63'(cell_i.t[30:0]);
  // divide by the constant: drop the power of two, then reciprocal multiply
  assign prod_b = 70'(a_v_r >> SHIFT) * 70'(RECIP);
  assign quo    = prod_b[68:37];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      valid_r   <= 1'b0;
    end else if (en) begin
      a_valid_r <= valid_i;
      valid_r   <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_v_r      <= prod_a[61:30];
      a_y_r      <= cell_i.y;
      a_neg_r    <= cell_i.neg;
      cell_r.y   <= a_y_r;
      cell_r.neg <= a_neg_r;
      cell_r.t   <= $signed(wcg_pkg::Q30_ONE - quo);
    end
  end

  assign valid_o = valid_r;
  assign cell_o  = cell_r;
endmodule
`default_nettype wire

[design/wcg_cos_lane.sv]
// Cosine of a phase in turns: quadrant fold, angle, square, Horner cells, sign.
`default_nettype none
module wcg_cos_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               valid_i,
  input  wire logic [31:0]        phase_i,
  output logic                    valid_o,
  output logic signed [31:0]      cos_o
);
  logic [1:0]          quad;
  logic [30:0]         r_nxt;
  logic [61:0]         prod_x;
  logic [61:0]         prod_y;
  logic                l0_valid_r, l1_valid_r, l2_valid_r, fin_valid_r;
  logic [30:0]         l0_r_r;
  logic                l0_neg_r, l1_neg_r;
  logic [30:0]         l1_x_r;
  wcg_pkg::wcg_hcell_t l2_cell_r;
  logic signed [31:0]  fin_cos_r;
  logic                hv [wcg_pkg::HCELLS+1];
  wcg_pkg::wcg_hcell_t hc [wcg_pkg::HCELLS+1];

  // fold into the first quarter turn
  assign quad  = phase_i[31:30];
  assign r_nxt = quad[0] ? 31'(wcg_pkg::Q30_ONE) - {1'b0, phase_i[29:0]}
                         : {1'b0, phase_i[29:0]};
  assign prod_x = 62'(l0_r_r) * 62'(wcg_pkg::HALF_PI_Q30);
  assign prod_y = 62'(l1_x_r) * 62'(l1_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_valid_r  <= 1'b0;
      l1_valid_r  <= 1'b0;
      l2_valid_r  <= 1'b0;
      fin_valid_r <= 1'b0;
    end else if (en) begin
      l0_valid_r  <= valid_i;
      l1_valid_r  <= l0_valid_r;
      l2_valid_r  <= l1_valid_r;
      fin_valid_r <= hv[wcg_pkg::HCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0_r_r        <= r_nxt;
      l0_neg_r      <= (quad == 2'd1) || (quad == 2'd2);
      l1_x_r        <= prod_x[60:30];
      l1_neg_r      <= l0_neg_r;
      l2_cell_r.y   <= prod_y[61:30];
      l2_cell_r.t   <= $signed(wcg_pkg::Q30_ONE);
      l2_cell_r.neg <= l1_neg_r;
      fin_cos_r     <= hc[wcg_pkg::HCELLS].neg ? -hc[wcg_pkg::HCELLS].t
                                                : hc[wcg_pkg::HCELLS].t;
    end
  end

  assign hv[0] = l2_valid_r;
  assign hc[0] = l2_cell_r;

  // chain of Horner cells
  for (genvar i = 0; i < wcg_pkg::HCELLS; i++) begin : g_horner
    wcg_horner_cell #(.STEP(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (hv[i]),
      .cell_i  (hc[i]),
      .valid_o (hv[i+1]),
      .cell_o  (hc[i+1])
    );
  end

  assign valid_o = fin_valid_r;
  assign cos_o   = fin_cos_r;
endmodule
`default_nettype wire

[design/window_coefficient_generator_core.sv]
// Window coefficient generator: cosine-sum window value for a sample index.
//
// Usage: write window_type (register 0) and window_length (register 1) on
// cfg_ch while no beats are in flight; cfg_ch is always ready. Each beat on
// in_ch carries a sample_index; one beat leaves out_ch per input beat, in
// order, with the Q1.16 coefficient and index_in_range.
// The pipeline has 67 register stages: 48 divider cells (one quotient bit
// each), 16 cosine-lane stages, two cosine-sum stages and the output
// register. Throughput is one beat per cycle while out_ch is ready; the
// whole chain advances on one shared enable.
// When out_ch stalls with a beat waiting, the chain freezes and in_ch.ready
// drops until that beat is taken.
// Reset clears every valid bit and loads the Hann window with length 1024.
// Indexes at or beyond the length return zero with index_in_range low.
`default_nettype none
module window_coefficient_generator_core (
  input  wire logic clk,
  input  wire logic rst_n,
  wcg_in_if.sink    in_ch,
  wcg_out_if.source out_ch,
  wcg_cfg_if.sink   cfg_ch
);
  `include "window_coefficient_generator_core_assert.svh"

  logic                          en;
  logic [wcg_pkg::TYPE_W-1:0]    type_r;
  logic [wcg_pkg::LEN_W-1:0]     len_r;
  logic [wcg_pkg::LEN_W-1:0]     len_sat;
  logic [15:0]                   d_in;
  wcg_pkg::wcg_div_t             div_in;
  logic                          dv [wcg_pkg::DIV_CELLS+1];
  wcg_pkg::wcg_div_t             db [wcg_pkg::DIV_CELLS+1];
  logic [31:0]                   p1, p2, p3;
  logic                          lv1, lv2, lv3;
  logic signed [31:0]            c1, c2, c3;
  wcg_pkg::wcg_side_t            side_r [wcg_pkg::LANE_STAGES];
  wcg_pkg::wcg_q30_t             a1, a2, a3;
  logic                          s1_valid_r, s2_valid_r;
  wcg_pkg::wcg_side_t            s1_side_r, s2_side_r;
  wcg_pkg::wcg_q30_t             s1_a0_r;
  logic signed [63:0]            s1_m1_r, s1_m2_r, s1_m3_r;
  logic signed [63:0]            base;
  logic signed [63:0]            s2_w_r;
  logic [60:0]                   wpos;
  logic [61:0]                   wrnd;
  logic [wcg_pkg::COEF_W-1:0]    coef_calc;
  logic [wcg_pkg::COEF_W-1:0]    coef_nxt;
  logic                          out_valid_r;
  logic [wcg_pkg::COEF_W-1:0]    out_coef_r;
  logic                          out_rng_r;

  // the chain moves unless a finished beat waits at the output
  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= wcg_pkg::TYPE_RESET;
      len_r  <= wcg_pkg::LEN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        wcg_pkg::REG_TYPE: type_r <= cfg_ch.data[wcg_pkg::TYPE_W-1:0];
        wcg_pkg::REG_LEN:  len_r  <= cfg_ch.data[wcg_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // divider input: (n * 2^32 + d/2) / d, with d = N - 1
  always_comb begin
    len_sat = (len_r > wcg_pkg::LEN_MAX) ? wcg_pkg::LEN_MAX : len_r;
    d_in    = 16'(len_sat - 17'd1);
    div_in.d   = d_in;
    div_in.rem = '0;
    div_in.num = {in_ch.sample_index, 16'd0, d_in};
    div_in.num[31:0] = {17'd0, d_in[15:1]};
    div_in.quo = '0;
    div_in.side.in_range = {1'b0, in_ch.sample_index} < len_sat;
    div_in.side.special  = (len_sat <= 17'd1) || (type_r == wcg_pkg::WIN_RECT) ||
                           (type_r > wcg_pkg::WIN_BH4);
  end

  assign dv[0] = in_ch.valid;
  assign db[0] = div_in;

  // chain of division cells
  for (genvar i = 0; i < wcg_pkg::DIV_CELLS; i++) begin : g_div
    wcg_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (dv[i]),
      .div_i   (db[i]),
      .valid_o (dv[i+1]),
      .div_o   (db[i+1])
    );
  end

  // phases of one, two and three times the angle
  assign p1 = db[wcg_pkg::DIV_CELLS].quo;
  assign p2 = {p1[30:0], 1'b0};
  assign p3 = p1 + p2;

  wcg_cos_lane u_lane1 (.clk(clk), .rst_n(rst_n), .en(en), .valid_i(dv[wcg_pkg::DIV_CELLS]),
                        .phase_i(p1), .valid_o(lv1), .cos_o(c1));
  wcg_cos_lane u_lane2 (.clk(clk), .rst_n(rst_n), .en(en), .valid_i(dv[wcg_pkg::DIV_CELLS]),
                        .phase_i(p2), .valid_o(lv2), .cos_o(c2));
  wcg_cos_lane u_lane3 (.clk(clk), .rst_n(rst_n), .en(en), .valid_i(dv[wcg_pkg::DIV_CELLS]),
                        .phase_i(p3), .valid_o(lv3), .cos_o(c3));

  // sideband delay matching the cosine lanes
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= db[wcg_pkg::DIV_CELLS].side;
      for (int i = 1; i < wcg_pkg::LANE_STAGES; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign a1 = wcg_pkg::win_coef(type_r, 1);
  assign a2 = wcg_pkg::win_coef(type_r, 2);
  assign a3 = wcg_pkg::win_coef(type_r, 3);
  assign base = $signed({3'b0, s1_a0_r, 30'b0});

  // round the Q4.60 sum to Q1.16, clamped to [0, 1.0]
  always_comb begin
    if (s2_w_r[63]) begin
      wpos = '0;
    end else if (s2_w_r[60:0] > wcg_pkg::TOP_W || s2_w_r[62:61] != 2'b00) begin
      wpos = wcg_pkg::TOP_W;
    end else begin
      wpos = s2_w_r[60:0];
    end
    wrnd = (62'(wpos) + wcg_pkg::ROUND_HALF) >> wcg_pkg::OUT_SHIFT;
    coef_calc = (wrnd > 62'(wcg_pkg::ONE_OUT)) ? wcg_pkg::ONE_OUT : wrnd[16:0];
    if (!s2_side_r.in_range) begin
      coef_nxt = '0;
    end else if (s2_side_r.special) begin
      coef_nxt = wcg_pkg::ONE_OUT;
    end else begin
      coef_nxt = coef_calc;
    end
  end

  // cosine-sum stages and output register: valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= lv1;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // cosine-sum stages and output register: payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r  <= side_r[wcg_pkg::LANE_STAGES-1];
      s1_a0_r    <= wcg_pkg::win_coef(type_r, 0);
      s1_m1_r    <= $signed({1'b0, a1}) * c1;
      s1_m2_r    <= $signed({1'b0, a2}) * c2;
      s1_m3_r    <= $signed({1'b0, a3}) * c3;
      s2_side_r  <= s1_side_r;
      s2_w_r     <= base - s1_m1_r + s1_m2_r - s1_m3_r;
      out_coef_r <= coef_nxt;
      out_rng_r  <= s2_side_r.in_range;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.coefficient    = out_coef_r;
  assign out_ch.index_in_range = out_rng_r;

  `WCG_ASSERT_ALWAYS(a_lanes_aligned, (lv1 == lv2) && (lv2 == lv3))
  `WCG_ASSERT_IMP(a_out_of_range_zero, out_valid_r && !out_rng_r, out_coef_r == '0)
  `WCG_ASSERT_IMP(a_coef_clamped, out_valid_r, out_coef_r <= wcg_pkg::ONE_OUT)
endmodule
`default_nettype wire
